[rtl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Fixed field widths
    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT        = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_PUT_COLOR  = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_CLEAR      = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_SET_COLORS = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_READ       = CMD_W'(4);

    // Character codes
    localparam logic [BYTE_W-1:0] BLANK   = 8'h20;
    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_PUT_IN,
        OP_READ_IN,
        OP_EMPTY,
        OP_SCROLL,
        OP_FILL,
        OP_INIT,
        OP_PUT_LAT
    } dp_op_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic at_end;
        logic scroll_last;
        logic fill_last;
    } tcw_status_t;

endpackage

`default_nettype wire

[rtl/text_console_writer.sv]
// Text console writer: keeps a COLUMNS x ROWS text screen (character store,
// attribute store, cursor). A command is transferred when start is high and
// busy is low; its result appears on the result ports for exactly one cycle
// with done high and cannot be held off, so the receiver must take it then.
// Puts that do not scroll, reads and unknown codes may be issued back to
// back; the result appears in the cycle after the transfer. A put with the
// cursor past the end first scrolls: the character store is walked through
// its single write port. Clear and set-all-colors sweep one cell per cycle.
// After reset busy stays high while both stores are cleared to zero.
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [BYTE_W-1:0] char_code,
    input  wire logic [BYTE_W-1:0] color,
    input  wire logic [POS_W-1:0]  cell_index,
    output logic                   done,
    output logic [POS_W-1:0]       cursor_pos,
    output logic                   scrolled,
    output logic [BYTE_W-1:0]      read_char,
    output logic [BYTE_W-1:0]      read_attr
);

    dp_op_t      op;
    tcw_status_t status;

    // Sequencer
    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    // Stores, cursor and result registers
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .cmd        (cmd),
        .char_code  (char_code),
        .color      (color),
        .cell_index (cell_index),
        .status     (status),
        .done       (done),
        .cursor_pos (cursor_pos),
        .scrolled   (scrolled),
        .read_char  (read_char),
        .read_attr  (read_attr)
    );

endmodule

`default_nettype wire

[rtl/tcw_ctrl.sv]
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [CMD_W-1:0] cmd,
    input  wire tcw_status_t      status,
    output dp_op_t                op,
    output logic                  busy
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_PUT,
        ST_FILL
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and operation decode
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_INIT:
            begin
                op = OP_INIT;
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_PUT, CMD_PUT_COLOR:
                        begin
                            if (status.at_end)
                            begin
                                op         = OP_START;
                                state_next = ST_SCROLL;
                            end
                            else
                            begin
                                op = OP_PUT_IN;
                            end
                        end
                        CMD_CLEAR, CMD_SET_COLORS:
                        begin
                            op         = OP_START;
                            state_next = ST_FILL;
                        end
                        CMD_READ:
                        begin
                            op = OP_READ_IN;
                        end
                        default:
                        begin
                            op = OP_EMPTY;
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                op = OP_SCROLL;
                if (status.scroll_last)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                op         = OP_PUT_LAT;
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                op = OP_FILL;
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; reset starts the store clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

[rtl/tcw_datapath.sv]
`default_nettype none

module tcw_datapath import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_op_t            op,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [BYTE_W-1:0] char_code,
    input  wire logic [BYTE_W-1:0] color,
    input  wire logic [POS_W-1:0]  cell_index,
    output tcw_status_t            status,
    output logic                   done,
    output logic [POS_W-1:0]       cursor_pos,
    output logic                   scrolled,
    output logic [BYTE_W-1:0]      read_char,
    output logic [BYTE_W-1:0]      read_attr
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int XW    = $clog2(COLUMNS);

    // Screen stores
    logic [BYTE_W-1:0] char_mem [CELLS];
    logic [BYTE_W-1:0] attr_mem [CELLS];
    logic [BYTE_W-1:0] char_q_reg;
    logic [BYTE_W-1:0] attr_q_reg;

    // Cursor, its column, sweep counter
    logic [CW-1:0]     cursor_reg, cursor_next;
    logic [XW-1:0]     col_reg, col_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    // Command latched for multi-cycle work
    logic [CMD_W-1:0]  cmd_lat_reg, cmd_lat_next;
    logic [BYTE_W-1:0] char_lat_reg, char_lat_next;
    logic [BYTE_W-1:0] color_lat_reg, color_lat_next;

    // Result flags
    logic              done_reg, done_next;
    logic              scrolled_reg, scrolled_next;
    logic              rd_flag_reg, rd_flag_next;

    // Store port controls
    logic              char_we, attr_we, char_re, attr_re;
    logic [AW-1:0]     char_wa, attr_wa, char_ra;
    logic [BYTE_W-1:0] char_wd, attr_wd;

    // Put operands, from the ports or from the latch
    logic [CMD_W-1:0]  p_cmd;
    logic [BYTE_W-1:0] p_char, p_color;
    logic [CW:0]       src_addr;
    logic              rd_in_range;

    assign p_cmd       = (op == OP_PUT_LAT) ? cmd_lat_reg   : cmd;
    assign p_char      = (op == OP_PUT_LAT) ? char_lat_reg  : char_code;
    assign p_color     = (op == OP_PUT_LAT) ? color_lat_reg : color;
    assign src_addr    = (CW+1)'(cnt_reg) + (CW+1)'(COLUMNS);
    assign rd_in_range = (int'(cell_index) < CELLS);

    assign status.at_end      = (cursor_reg == CW'(CELLS));
    assign status.scroll_last = (cnt_reg == CW'(CELLS));
    assign status.fill_last   = (cnt_reg == CW'(CELLS - 1));

    // Operation decode
    always_comb
    begin
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        cmd_lat_next   = cmd_lat_reg;
        char_lat_next  = char_lat_reg;
        color_lat_next = color_lat_reg;
        done_next      = 1'b0;
        scrolled_next  = 1'b0;
        rd_flag_next   = 1'b0;
        char_we        = 1'b0;
        attr_we        = 1'b0;
        char_re        = 1'b0;
        attr_re        = 1'b0;
        char_wa        = AW'(cursor_reg);
        attr_wa        = AW'(cursor_reg);
        char_ra        = AW'(cell_index);
        char_wd        = p_char;
        attr_wd        = p_color;
        unique case (op)
            OP_PUT_IN, OP_PUT_LAT:
            begin
                done_next     = 1'b1;
                scrolled_next = (op == OP_PUT_LAT);
                if (p_char == NEWLINE)
                begin
                    cursor_next = cursor_reg + (CW'(COLUMNS) - CW'(col_reg));
                    col_next    = '0;
                end
                else
                begin
                    char_we     = 1'b1;
                    attr_we     = (p_cmd == CMD_PUT_COLOR);
                    cursor_next = cursor_reg + CW'(1);
                    col_next    = (col_reg == XW'(COLUMNS - 1)) ? '0 : col_reg + XW'(1);
                end
            end
            OP_READ_IN:
            begin
                done_next    = 1'b1;
                rd_flag_next = rd_in_range;
                char_re      = rd_in_range;
                attr_re      = rd_in_range;
            end
            OP_EMPTY:
            begin
                done_next = 1'b1;
            end
            OP_START:
            begin
                cmd_lat_next   = cmd;
                char_lat_next  = char_code;
                color_lat_next = color;
                cnt_next       = '0;
            end
            OP_SCROLL:
            begin
                // read one row below, write back in the next cycle
                char_re  = (src_addr < (CW+1)'(CELLS));
                char_ra  = AW'(src_addr);
                char_wa  = AW'(cnt_reg - CW'(1));
                char_we  = (cnt_reg != '0);
                char_wd  = (cnt_reg <= CW'(CELLS - COLUMNS)) ? char_q_reg : BLANK;
                cnt_next = cnt_reg + CW'(1);
                if (status.scroll_last)
                begin
                    cursor_next = CW'(CELLS - COLUMNS);
                    col_next    = '0;
                end
            end
            OP_FILL:
            begin
                char_wa  = AW'(cnt_reg);
                attr_wa  = AW'(cnt_reg);
                char_wd  = BLANK;
                attr_wd  = color_lat_reg;
                char_we  = (cmd_lat_reg == CMD_CLEAR);
                attr_we  = (cmd_lat_reg != CMD_CLEAR);
                cnt_next = cnt_reg + CW'(1);
                if (status.fill_last)
                begin
                    done_next = 1'b1;
                    if (cmd_lat_reg == CMD_CLEAR)
                    begin
                        cursor_next = '0;
                        col_next    = '0;
                    end
                end
            end
            OP_INIT:
            begin
                char_wa  = AW'(cnt_reg);
                attr_wa  = AW'(cnt_reg);
                char_wd  = '0;
                attr_wd  = '0;
                char_we  = 1'b1;
                attr_we  = 1'b1;
                cnt_next = cnt_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            col_reg      <= '0;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
            scrolled_reg <= 1'b0;
            rd_flag_reg  <= 1'b0;
        end
        else
        begin
            cursor_reg   <= cursor_next;
            col_reg      <= col_next;
            cnt_reg      <= cnt_next;
            done_reg     <= done_next;
            scrolled_reg <= scrolled_next;
            rd_flag_reg  <= rd_flag_next;
        end
    end

    // Latched command payload
    always_ff @(posedge clk)
    begin
        cmd_lat_reg   <= cmd_lat_next;
        char_lat_reg  <= char_lat_next;
        color_lat_reg <= color_lat_next;
    end

    // Character store
    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[char_wa] <= char_wd;
        end
        if (char_re)
        begin
            char_q_reg <= char_mem[char_ra];
        end
    end

    // Attribute store
    always_ff @(posedge clk)
    begin
        if (attr_we)
        begin
            attr_mem[attr_wa] <= attr_wd;
        end
        if (attr_re)
        begin
            attr_q_reg <= attr_mem[char_ra];
        end
    end

    // Result outputs
    assign done       = done_reg;
    assign scrolled   = scrolled_reg;
    assign cursor_pos = POS_W'(cursor_reg);
    assign read_char  = rd_flag_reg ? char_q_reg : '0;
    assign read_attr  = rd_flag_reg ? attr_q_reg : '0;

endmodule

`default_nettype wire
